@@ src/gspc_pkg.sv @@
package gspc_pkg;

    localparam int VOLT_W     = 13;
    localparam int GAP_W      = 14;
    localparam int RES_W      = 24;
    localparam int RATIO_W    = 16;
    localparam int K_W        = 14;
    localparam int FRAC_W     = 14;
    localparam int SLOT_W     = 3;
    localparam int ACTION_W   = 2;
    localparam int CLASS_W    = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 14;

    localparam int SAMPLE_COUNT_DEFAULT = 8;

    localparam int RES_NUM_W  = VOLT_W + 12;
    localparam int DIV_NUM_W  = RES_W + FRAC_W;
    localparam int DIV_DEN_W  = RES_W;
    localparam int DIV_Q_W    = RES_W;
    localparam int DIV_CNT_W  = $clog2(DIV_Q_W + 1);

    localparam logic [RES_W-1:0]   RES_MAX   = {RES_W{1'b1}};
    localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};
    localparam logic [K_W-1:0]     K_DEFAULT = K_W'(13763);
    localparam int K_SCALE = 100;
    localparam int K_HIGH  = 96;
    localparam int K_LOW   = 6;

    localparam logic [ACTION_W-1:0] ACT_STORE    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_BASELINE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_JUDGE    = 2'd2;

    localparam logic [CLASS_W-1:0] CLASS_CLEAN    = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_LIGHT    = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_MODERATE = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_HEAVY    = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_REFERENCE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RISE_ONE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RISE_TWO   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RISE_THREE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FALL_ONE   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_FALL_TWO   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_FALL_THREE = 3'd6;

    localparam logic [VOLT_W-1:0] REFERENCE_RESET  = VOLT_W'(2500);
    localparam logic [GAP_W-1:0]  RISE_ONE_RESET   = GAP_W'(1638);
    localparam logic [GAP_W-1:0]  RISE_TWO_RESET   = GAP_W'(3277);
    localparam logic [GAP_W-1:0]  RISE_THREE_RESET = GAP_W'(4915);
    localparam logic [GAP_W-1:0]  FALL_ONE_RESET   = GAP_W'(819);
    localparam logic [GAP_W-1:0]  FALL_TWO_RESET   = GAP_W'(2458);
    localparam logic [GAP_W-1:0]  FALL_THREE_RESET = GAP_W'(4096);

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SLOT_W-1:0]   slot;
        logic [VOLT_W-1:0]   supply_mv;
        logic [VOLT_W-1:0]   load_mv;
    } sample_item_t;

    typedef struct packed {
        logic [CLASS_W-1:0] pollution_class;
        logic [RES_W-1:0]   average_resistance;
        logic [RATIO_W-1:0] resistance_ratio;
        logic               ratio_saturated;
    } result_item_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
        logic [DIV_CNT_W-1:0] qbits;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DIV_Q_W-1:0] quotient;
    } div_rsp_t;

    function automatic int store_depth(int count);
        int slots;
        slots = 2 ** SLOT_W;
        return (count < slots) ? count : slots;
    endfunction

    function automatic int sum_width(int count);
        return RES_W + $clog2(store_depth(count));
    endfunction

endpackage

@@ src/gas_sensor_pollution_classifier_core.sv @@
// Gas sensor pollution classifier.
// Items enter on sample_valid/sample_ready and results leave on
// result_valid/result_ready; every accepted item gives exactly one result item.
// Configuration registers are written through cfg_we, cfg_index and cfg_data
// while the block is idle; the user must keep to this, as the block does not
// enforce it. A write takes effect at the same clock edge.
// A store item divides for the sensor resistance on the shared restoring
// divider, or fixes the resistance at zero or at its maximum without a division.
// A judge item uses the divider for the ratio and for K, for only one of them,
// or for neither; a baseline item or an unused action takes no division.
// The divider resolves one quotient bit per cycle.
// The block takes one item at a time; sample_ready is high only while idle and
// returns together with result_valid when a result is registered.
// A finished result waits in the output register, so the next item is taken
// while the receiver stalls, and its result waits until the register frees.
// Reset clears the sample store, the baseline and the class history and sets the
// configuration registers to defaults; the block is ready right after reset.
module gas_sensor_pollution_classifier_core #(
    parameter int SAMPLE_COUNT = gspc_pkg::SAMPLE_COUNT_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  gspc_pkg::sample_item_t              sample_item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output gspc_pkg::result_item_t              result_item,
    input  logic                                cfg_we,
    input  logic [gspc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [gspc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int VOLT_W    = gspc_pkg::VOLT_W;
    localparam int GAP_W     = gspc_pkg::GAP_W;
    localparam int RES_W     = gspc_pkg::RES_W;
    localparam int RATIO_W   = gspc_pkg::RATIO_W;
    localparam int K_W       = gspc_pkg::K_W;
    localparam int FRAC_W    = gspc_pkg::FRAC_W;
    localparam int CLASS_W   = gspc_pkg::CLASS_W;
    localparam int NUM_W     = gspc_pkg::DIV_NUM_W;
    localparam int DEN_W     = gspc_pkg::DIV_DEN_W;
    localparam int CNT_W     = gspc_pkg::DIV_CNT_W;
    localparam int RES_NUM_W = gspc_pkg::RES_NUM_W;
    localparam int SUM_W     = gspc_pkg::sum_width(SAMPLE_COUNT);
    localparam int SAT_W     = VOLT_W + RES_W;
    localparam int RANGE_W   = VOLT_W + 7;
    localparam int CMP_W     = RATIO_W + 2;

    // The store average divides by the slot count through a rounded-up
    // reciprocal, which is exact over the whole range of the sum.
    localparam int AVG_SHIFT = SUM_W + $clog2(SAMPLE_COUNT);
    localparam int AVG_MUL_W = SUM_W + 1;
    localparam int PROD_W    = SUM_W + AVG_MUL_W;
    localparam logic [AVG_MUL_W-1:0] AVG_MUL =
        AVG_MUL_W'(((64'd1 << AVG_SHIFT) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT));

    typedef enum logic [3:0] {
        S_IDLE,
        S_STORE_PREP,
        S_RES_DIV,
        S_STORE_WRITE,
        S_AVG_START,
        S_JUDGE_PREP,
        S_RATIO_DIV,
        S_K_PREP,
        S_K_DIV,
        S_CLASS,
        S_OUT
    } state_t;

    state_t                   state_reg, state_next;
    logic                     result_valid_reg, result_valid_next;
    gspc_pkg::result_item_t   result_reg, result_next;

    gspc_pkg::sample_item_t   item_reg, item_next;
    logic [RES_W-1:0]         res_reg, res_next;
    logic [RATIO_W-1:0]       ratio_reg, ratio_next;
    logic                     sat_reg, sat_next;
    logic [K_W-1:0]           k_reg, k_next;

    logic [RES_W-1:0]         avg_reg, avg_next;
    logic [RES_W-1:0]         base_reg, base_next;
    logic [CLASS_W-1:0]       class_reg, class_next;
    logic [CLASS_W-1:0]       prev_reg, prev_next;

    logic [VOLT_W-1:0]        ref_reg;
    logic [GAP_W-1:0]         rise_one_reg, rise_two_reg, rise_three_reg;
    logic [GAP_W-1:0]         fall_one_reg, fall_two_reg, fall_three_reg;

    gspc_pkg::div_req_t       div_req;
    gspc_pkg::div_rsp_t       div_rsp;
    logic                     store_we;
    logic [SUM_W-1:0]         sum;
    logic [PROD_W-1:0]        avg_prod;

    logic [VOLT_W-1:0]        volt_diff;
    logic [RES_NUM_W-1:0]     res_num;
    logic                     res_zero;
    logic                     res_sat;
    logic                     ratio_sat;
    logic [RANGE_W-1:0]       ref_scaled, supply_high, supply_low;
    logic                     k_out_of_range;

    logic signed [CMP_W-1:0]  ratio_s;
    logic signed [CMP_W-1:0]  thr_rise_one, thr_rise_two, thr_rise_three;
    logic signed [CMP_W-1:0]  thr_fall_one, thr_fall_two, thr_fall_three;

    gspc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    gspc_store #(
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (store_we),
        .slot  (item_reg.slot),
        .value (res_reg),
        .sum   (sum)
    );

    assign volt_diff = item_reg.supply_mv - item_reg.load_mv;
    assign res_num   = (RES_NUM_W'(volt_diff) << 11) + (RES_NUM_W'(volt_diff) << 9);
    assign res_zero  = (item_reg.load_mv == '0) || (item_reg.load_mv > item_reg.supply_mv);
    assign res_sat   = SAT_W'(res_num) >= {item_reg.load_mv, {RES_W{1'b0}}};

    assign avg_prod  = PROD_W'(sum) * PROD_W'(AVG_MUL);

    assign ratio_sat = (RES_W + 2)'(avg_reg) >= {base_reg, 2'b00};

    assign ref_scaled  = RANGE_W'(ref_reg) * RANGE_W'(gspc_pkg::K_SCALE);
    assign supply_high = RANGE_W'(item_reg.supply_mv) * RANGE_W'(gspc_pkg::K_HIGH);
    assign supply_low  = RANGE_W'(item_reg.supply_mv) * RANGE_W'(gspc_pkg::K_LOW);
    assign k_out_of_range = (item_reg.supply_mv == '0) || (ref_scaled > supply_high)
                            || (ref_scaled < supply_low);

    assign ratio_s        = CMP_W'(ratio_reg);
    assign thr_rise_one   = CMP_W'(k_reg) - CMP_W'(rise_one_reg);
    assign thr_rise_two   = CMP_W'(k_reg) - CMP_W'(rise_two_reg);
    assign thr_rise_three = CMP_W'(k_reg) - CMP_W'(rise_three_reg);
    assign thr_fall_one   = CMP_W'(k_reg) - CMP_W'(fall_one_reg);
    assign thr_fall_two   = CMP_W'(k_reg) - CMP_W'(fall_two_reg);
    assign thr_fall_three = CMP_W'(k_reg) - CMP_W'(fall_three_reg);

    assign sample_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next        = state_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        item_next         = item_reg;
        res_next          = res_reg;
        ratio_next        = ratio_reg;
        sat_next          = sat_reg;
        k_next            = k_reg;
        avg_next          = avg_reg;
        base_next         = base_reg;
        class_next        = class_reg;
        prev_next         = prev_reg;
        div_req           = '0;
        store_we          = 1'b0;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    item_next  = sample_item;
                    ratio_next = '0;
                    sat_next   = 1'b0;
                    case (sample_item.action)
                        gspc_pkg::ACT_STORE:
                        begin
                            state_next = S_STORE_PREP;
                        end
                        gspc_pkg::ACT_BASELINE:
                        begin
                            if (avg_reg > base_reg)
                            begin
                                base_next = avg_reg;
                            end
                            state_next = S_OUT;
                        end
                        gspc_pkg::ACT_JUDGE:
                        begin
                            state_next = S_JUDGE_PREP;
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_STORE_PREP:
            begin
                if (res_zero)
                begin
                    res_next   = '0;
                    state_next = S_STORE_WRITE;
                end
                else if (res_sat)
                begin
                    res_next   = gspc_pkg::RES_MAX;
                    state_next = S_STORE_WRITE;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.num   = NUM_W'(res_num);
                    div_req.den   = DEN_W'(item_reg.load_mv);
                    div_req.qbits = CNT_W'(RES_W);
                    state_next    = S_RES_DIV;
                end
            end
            S_RES_DIV:
            begin
                if (div_rsp.done)
                begin
                    res_next   = div_rsp.quotient[RES_W-1:0];
                    state_next = S_STORE_WRITE;
                end
            end
            S_STORE_WRITE:
            begin
                store_we   = 1'b1;
                state_next = S_AVG_START;
            end
            S_AVG_START:
            begin
                avg_next   = RES_W'(avg_prod >> AVG_SHIFT);
                state_next = S_OUT;
            end
            S_JUDGE_PREP:
            begin
                if ((base_reg == '0) || ratio_sat)
                begin
                    ratio_next = gspc_pkg::RATIO_MAX;
                    sat_next   = 1'b1;
                    state_next = S_K_PREP;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.num   = {avg_reg, {FRAC_W{1'b0}}};
                    div_req.den   = base_reg;
                    div_req.qbits = CNT_W'(RATIO_W);
                    state_next    = S_RATIO_DIV;
                end
            end
            S_RATIO_DIV:
            begin
                if (div_rsp.done)
                begin
                    ratio_next = div_rsp.quotient[RATIO_W-1:0];
                    state_next = S_K_PREP;
                end
            end
            S_K_PREP:
            begin
                if (k_out_of_range)
                begin
                    k_next     = gspc_pkg::K_DEFAULT;
                    state_next = S_CLASS;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.num   = NUM_W'({ref_reg, {FRAC_W{1'b0}}});
                    div_req.den   = DEN_W'(item_reg.supply_mv);
                    div_req.qbits = CNT_W'(K_W);
                    state_next    = S_K_DIV;
                end
            end
            S_K_DIV:
            begin
                if (div_rsp.done)
                begin
                    k_next     = div_rsp.quotient[K_W-1:0];
                    state_next = S_CLASS;
                end
            end
            S_CLASS:
            begin
                case (class_reg)
                    gspc_pkg::CLASS_CLEAN:
                    begin
                        if (ratio_s <= thr_rise_one)
                        begin
                            class_next = gspc_pkg::CLASS_LIGHT;
                            prev_next  = class_reg;
                        end
                    end
                    gspc_pkg::CLASS_LIGHT:
                    begin
                        if ((ratio_s <= thr_rise_two) && (prev_reg == gspc_pkg::CLASS_CLEAN))
                        begin
                            class_next = gspc_pkg::CLASS_MODERATE;
                            prev_next  = class_reg;
                        end
                        else if ((ratio_s >= thr_fall_one)
                                 && (prev_reg == gspc_pkg::CLASS_MODERATE))
                        begin
                            class_next = gspc_pkg::CLASS_CLEAN;
                            prev_next  = class_reg;
                        end
                    end
                    gspc_pkg::CLASS_MODERATE:
                    begin
                        if ((ratio_s <= thr_rise_three) && (prev_reg == gspc_pkg::CLASS_LIGHT))
                        begin
                            class_next = gspc_pkg::CLASS_HEAVY;
                            prev_next  = class_reg;
                        end
                        else if ((ratio_s >= thr_fall_two)
                                 && (prev_reg == gspc_pkg::CLASS_HEAVY))
                        begin
                            class_next = gspc_pkg::CLASS_LIGHT;
                            prev_next  = class_reg;
                        end
                    end
                    default:
                    begin
                        if (ratio_s >= thr_fall_three)
                        begin
                            class_next = gspc_pkg::CLASS_MODERATE;
                            prev_next  = class_reg;
                        end
                    end
                endcase
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next                  = 1'b1;
                    result_next.pollution_class        = class_reg;
                    result_next.average_resistance     = avg_reg;
                    result_next.resistance_ratio       = ratio_reg;
                    result_next.ratio_saturated        = sat_reg;
                    state_next                         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        res_reg   <= res_next;
        ratio_reg <= ratio_next;
        sat_reg   <= sat_next;
        k_reg     <= k_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg   <= '0;
            base_reg  <= '0;
            class_reg <= gspc_pkg::CLASS_CLEAN;
            prev_reg  <= gspc_pkg::CLASS_CLEAN;
        end
        else
        begin
            avg_reg   <= avg_next;
            base_reg  <= base_next;
            class_reg <= class_next;
            prev_reg  <= prev_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg        <= gspc_pkg::REFERENCE_RESET;
            rise_one_reg   <= gspc_pkg::RISE_ONE_RESET;
            rise_two_reg   <= gspc_pkg::RISE_TWO_RESET;
            rise_three_reg <= gspc_pkg::RISE_THREE_RESET;
            fall_one_reg   <= gspc_pkg::FALL_ONE_RESET;
            fall_two_reg   <= gspc_pkg::FALL_TWO_RESET;
            fall_three_reg <= gspc_pkg::FALL_THREE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gspc_pkg::CFG_REFERENCE:  ref_reg        <= cfg_data[VOLT_W-1:0];
                gspc_pkg::CFG_RISE_ONE:   rise_one_reg   <= cfg_data[GAP_W-1:0];
                gspc_pkg::CFG_RISE_TWO:   rise_two_reg   <= cfg_data[GAP_W-1:0];
                gspc_pkg::CFG_RISE_THREE: rise_three_reg <= cfg_data[GAP_W-1:0];
                gspc_pkg::CFG_FALL_ONE:   fall_one_reg   <= cfg_data[GAP_W-1:0];
                gspc_pkg::CFG_FALL_TWO:   fall_two_reg   <= cfg_data[GAP_W-1:0];
                gspc_pkg::CFG_FALL_THREE: fall_three_reg <= cfg_data[GAP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_reg;

    // The shared divider is never restarted while a division is in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

    // The class only changes in the classification step.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(class_reg) |-> ($past(state_reg) == S_CLASS))
    else $error("class changed outside the classification step");

    // The class moves by one level at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(class_reg) |->
            ((CLASS_W'(class_reg - $past(class_reg)) == CLASS_W'(1))
             || (CLASS_W'($past(class_reg) - class_reg) == CLASS_W'(1))))
    else $error("class skipped a level");

    // The baseline maximum never decreases.
    assert property (@(posedge clk) disable iff (!rst_n)
        base_reg >= $past(base_reg))
    else $error("baseline decreased");

endmodule

@@ src/gspc_div.sv @@
module gspc_div (
    input  logic                clk,
    input  logic                rst_n,
    input  gspc_pkg::div_req_t  req,
    output gspc_pkg::div_rsp_t  rsp
);

    localparam int NUM_W = gspc_pkg::DIV_NUM_W;
    localparam int DEN_W = gspc_pkg::DIV_DEN_W;
    localparam int Q_W   = gspc_pkg::DIV_Q_W;
    localparam int CNT_W = gspc_pkg::DIV_CNT_W;
    localparam int DS_W  = DEN_W + Q_W - 1;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [DS_W-1:0]  ds_reg, ds_next;
    logic [Q_W-1:0]   quo_reg, quo_next;
    logic             fit;

    // The quotient is known to fit in qbits, so each step tries one shifted divisor.
    assign fit = DS_W'(rem_reg) >= ds_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        ds_next   = ds_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.qbits;
            rem_next  = req.num;
            ds_next   = DS_W'(req.den) << (req.qbits - CNT_W'(1));
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            if (fit)
            begin
                rem_next = rem_reg - NUM_W'(ds_reg);
            end
            quo_next = {quo_reg[Q_W-2:0], fit};
            ds_next  = ds_reg >> 1;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        ds_reg  <= ds_next;
        quo_reg <= quo_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ src/gspc_store.sv @@
module gspc_store #(
    parameter int SAMPLE_COUNT = gspc_pkg::SAMPLE_COUNT_DEFAULT
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           we,
    input  logic [gspc_pkg::SLOT_W-1:0]                    slot,
    input  logic [gspc_pkg::RES_W-1:0]                     value,
    output logic [gspc_pkg::sum_width(SAMPLE_COUNT)-1:0]   sum
);

    localparam int DEPTH = gspc_pkg::store_depth(SAMPLE_COUNT);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int SUM_W = gspc_pkg::sum_width(SAMPLE_COUNT);
    localparam int RES_W = gspc_pkg::RES_W;

    // Slots beyond the reach of the slot field always hold zero and take no storage.
    logic [RES_W-1:0] entry_reg [DEPTH];
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [IDX_W-1:0] idx;
    logic             slot_ok;
    logic [RES_W-1:0] old_value;

    assign slot_ok   = 32'(slot) < SAMPLE_COUNT;
    assign idx       = slot[IDX_W-1:0];
    assign old_value = entry_reg[idx];
    assign sum_next  = sum_reg - SUM_W'(old_value) + SUM_W'(value);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                entry_reg[i] <= '0;
            end
            sum_reg <= '0;
        end
        else if (we && slot_ok)
        begin
            entry_reg[idx] <= value;
            sum_reg        <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule
